>>> rtl/dbs_pkg.sv
package dbs_pkg;

	localparam int unsigned Capacity = 16;
	localparam int unsigned IdxW = $clog2(Capacity);
	localparam int unsigned CntW = $clog2(Capacity + 1);

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_CONTAINS   = 3'd4;
	localparam logic [2:0] OP_REMOVE     = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] front_value;
		logic signed [31:0] back_value;
		logic               found;
		logic [4:0]         count;
		logic [1:0]         status;
	} out_item_t;

endpackage

>>> rtl/deque_bag_store.sv
// Bounded double-ended queue of signed 32-bit values with search and
// remove-first-match. Entries live in a ring of Capacity words in one
// synchronous memory; a front pointer and a fill count give order. Pushes, pops
// and undefined opcodes pass through the accept state, a front read, a back
// read and the result state. Contains and remove first compare the entries
// one at a time, front to back, stopping at the first match. Remove of a match
// at position p with entries behind it then closes the gap by moving those
// entries forward, one read and one write per entry with the first read
// overlapped with the scan. The memory's single read port sets this sequence.
// A finished result is held until it is taken; no new item is taken until it
// has gone.
module deque_bag_store (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  dbs_pkg::in_item_t    in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output dbs_pkg::out_item_t   out_data
);
	import dbs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_RD_FRONT, S_RD_BACK, S_DONE
	} state_t;

	state_t           state_q;
	logic [IdxW-1:0]  head_q;
	logic [CntW-1:0]  cnt_q;
	logic [2:0]       op_q;
	logic [31:0]      val_q;
	logic [CntW-1:0]  pos_q;
	logic             found_q;
	logic [1:0]       status_q;
	logic [31:0]      front_q;
	logic             busy_q;

	logic [31:0]      mem [Capacity];
	logic [31:0]      rd_data;
	logic [IdxW-1:0]  rd_addr;
	logic             wr_en;
	logic [IdxW-1:0]  wr_addr;
	logic [31:0]      wr_data;

	// Logical position to physical slot in the ring.
	function automatic logic [IdxW-1:0] slot(input logic [IdxW-1:0] h,
		input logic [CntW-1:0] p);
		logic [CntW:0] s;
		s = {1'b0, p} + {{(CntW + 1 - IdxW){1'b0}}, h};
		if (s >= (CntW + 1)'(Capacity))
			s = s - (CntW + 1)'(Capacity);
		return s[IdxW-1:0];
	endfunction

	// Memory with one write and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end

	assign in_ready  = (state_q == S_IDLE) && !out_valid;
	assign out_valid = busy_q && (state_q == S_DONE);

	// Read address is chosen for the data needed in the next state. The back
	// address is held through the result state so the read data stays put.
	logic [CntW-1:0] pos_nx;
	always_comb begin
		rd_addr = head_q;
		wr_en   = 1'b0;
		wr_addr = head_q;
		wr_data = val_q;
		pos_nx  = pos_q + 1'b1;
		case (state_q)
			S_IDLE: begin
				rd_addr = head_q;
				if (in_valid && in_ready) begin
					if (in_data.opcode == OP_PUSH_FRONT && cnt_q < CntW'(Capacity)) begin
						wr_en   = 1'b1;
						wr_addr = slot(head_q, CntW'(Capacity - 1));
						wr_data = in_data.value;
					end else if (in_data.opcode == OP_PUSH_BACK &&
							cnt_q < CntW'(Capacity)) begin
						wr_en   = 1'b1;
						wr_addr = slot(head_q, cnt_q);
						wr_data = in_data.value;
					end
				end
			end
			S_SCAN:     rd_addr = slot(head_q, pos_nx);
			S_SHIFT_RD: rd_addr = slot(head_q, pos_nx);
			S_SHIFT_WR: begin
				wr_en   = 1'b1;
				wr_addr = slot(head_q, pos_q);
				wr_data = rd_data;
				rd_addr = head_q;
			end
			S_RD_FRONT: rd_addr = head_q;
			S_RD_BACK,
			S_DONE:     rd_addr = slot(head_q, cnt_q - 1'b1);
			default:    rd_addr = head_q;
		endcase
	end

	// Sequencer holding the store pointers and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			cnt_q    <= '0;
			busy_q   <= 1'b0;
			op_q     <= OP_PUSH_FRONT;
			val_q    <= '0;
			pos_q    <= '0;
			found_q  <= 1'b0;
			status_q <= ST_OK;
			front_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						op_q     <= in_data.opcode;
						val_q    <= in_data.value;
						found_q  <= 1'b0;
						status_q <= ST_OK;
						pos_q    <= '0;
						busy_q   <= 1'b1;
						state_q  <= S_RD_FRONT;
						case (in_data.opcode)
							OP_PUSH_FRONT, OP_PUSH_BACK: begin
								if (cnt_q >= CntW'(Capacity))
									status_q <= ST_FULL;
								else begin
									cnt_q <= cnt_q + 1'b1;
									if (in_data.opcode == OP_PUSH_FRONT)
										head_q <= slot(head_q, CntW'(Capacity - 1));
								end
							end
							OP_POP_FRONT, OP_POP_BACK: begin
								if (cnt_q == '0)
									status_q <= ST_EMPTY;
								else begin
									cnt_q <= cnt_q - 1'b1;
									if (in_data.opcode == OP_POP_FRONT)
										head_q <= slot(head_q, CntW'(1));
								end
							end
							OP_CONTAINS, OP_REMOVE: begin
								if (cnt_q == '0)
									status_q <= ST_EMPTY;
								else
									state_q <= S_SCAN;
							end
							default: ;
						endcase
					end
				end
				// Read data for position pos_q is valid here.
				S_SCAN: begin
					if (rd_data == val_q) begin
						found_q <= 1'b1;
						if (op_q == OP_REMOVE) begin
							if (pos_q + 1'b1 >= cnt_q) begin
								cnt_q   <= cnt_q - 1'b1;
								state_q <= S_RD_FRONT;
							end else
								state_q <= S_SHIFT_WR;
						end else
							state_q <= S_RD_FRONT;
					end else if (pos_q + 1'b1 >= cnt_q)
						state_q <= S_RD_FRONT;
					else
						pos_q <= pos_nx;
				end
				// Entry pos_q+1 is being read; next cycle it is written to position pos_q.
				S_SHIFT_RD: state_q <= S_SHIFT_WR;
				S_SHIFT_WR: begin
					pos_q <= pos_nx;
					if (pos_q + 2'd2 >= cnt_q) begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= S_RD_FRONT;
					end else
						state_q <= S_SHIFT_RD;
				end
				S_RD_FRONT: state_q <= S_RD_BACK;
				S_RD_BACK: begin
					front_q <= (cnt_q == '0) ? '0 : rd_data;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_valid && out_ready) begin
						busy_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The back value comes straight from the held memory read.
	always_comb begin
		out_data.front_value = front_q;
		out_data.back_value  = (cnt_q == '0) ? '0 : rd_data;
		out_data.found       = found_q;
		out_data.count       = 5'(cnt_q);
		out_data.status      = status_q;
	end

	// The fill count never exceeds the capacity.
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CntW'(Capacity))
		else $error("fill count above capacity");
	// A full status is only reported when the store is at capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && status_q == ST_FULL) |-> cnt_q == CntW'(Capacity))
		else $error("full status with room left");
	// Found is only reported for searches.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.found) |-> (op_q == OP_CONTAINS || op_q == OP_REMOVE))
		else $error("found set on a non-search item");
	// No item is taken while a result waits.
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !in_ready)
		else $error("input accepted while result pending");

endmodule

>>> dv/deque_bag_store_tb.sv
module deque_bag_store_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dbs_pkg::*;

	// Expected-result store with its own model of the deque contents.
	class deque_scoreboard;
		logic signed [31:0] slots[$];
		out_item_t pending[$];
		int mismatches;

		// Work out the result that an accepted item must give.
		function void note_item(in_item_t it);
			out_item_t r;
			int pos;
			r = '0;
			r.status = ST_OK;
			pos = -1;
			case (it.opcode)
				OP_PUSH_FRONT, OP_PUSH_BACK: begin
					if (slots.size() >= Capacity)
						r.status = ST_FULL;
					else if (it.opcode == OP_PUSH_FRONT)
						slots.push_front(it.value);
					else
						slots.push_back(it.value);
				end
				OP_POP_FRONT, OP_POP_BACK: begin
					if (slots.size() == 0)
						r.status = ST_EMPTY;
					else if (it.opcode == OP_POP_FRONT)
						void'(slots.pop_front());
					else
						void'(slots.pop_back());
				end
				OP_CONTAINS, OP_REMOVE: begin
					if (slots.size() == 0) begin
						r.status = ST_EMPTY;
					end else begin
						for (int i = 0; i < slots.size(); i++)
							if (pos < 0 && slots[i] == it.value)
								pos = i;
						r.found = (pos >= 0);
						if (pos >= 0 && it.opcode == OP_REMOVE)
							slots.delete(pos);
					end
				end
				default: ;
			endcase
			if (slots.size() > 0) begin
				r.front_value = slots[0];
				r.back_value = slots[slots.size() - 1];
			end
			r.count = 5'(slots.size());
			pending.push_back(r);
		endfunction

		// Compare a result with the oldest expectation.
		function void check_result(out_item_t got);
			out_item_t exp_r;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", got);
				return;
			end
			exp_r = pending.pop_front();
			if (got.front_value !== exp_r.front_value || got.back_value !== exp_r.back_value
					|| got.found !== exp_r.found || got.count !== exp_r.count
					|| got.status !== exp_r.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %p, got %p", exp_r, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	out_item_t out_data;
	deque_scoreboard sb = new();
	bit sending_done = 0;
	bit hold_off = 0;
	logic signed [31:0] recent[$];
	longint cycles = 0;

	deque_bag_store DUT (.*);

	always #5 clk = ~clk;

	// Watchdog: every item may scan and shift the whole store and wait out both stalls.
	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("deque_bag_store_tb: FAIL");
			$finish;
		end
	end

	// Note accepted items and check results at the rising edge.
	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.note_item(in_data);
		if (out_valid && out_ready)
			sb.check_result(out_data);
	end

	// Offer one item after a random gap and hold it until it is taken.
	// Valid is only dropped when a gap follows.
	task automatic send_item(logic [2:0] op, logic signed [31:0] val, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_data <= '{opcode: op, value: val};
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (recent.size() > 8)
			void'(recent.pop_front());
		recent.push_back(val);
	endtask

	// Pick a value, often one that was pushed lately so that searches hit.
	function automatic logic signed [31:0] pick_value();
		int k;
		k = $urandom_range(0, 9);
		if (k < 5 && recent.size() > 0)
			return recent[$urandom_range(0, recent.size() - 1)];
		if (k == 5)
			return 32'sh7fffffff;
		if (k == 6)
			return 32'sh80000000;
		return $urandom_range(0, 15) + (k == 7 ? 0 : $urandom);
	endfunction

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 0;
				repeat (300) @(negedge clk);
				hold_off = 0;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				out_ready <= 0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Stimulus: directed extremes first, then random sequences.
	initial begin
		logic [2:0] op;
		int mode;
		repeat (6) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		send_item(OP_POP_FRONT, 0, 0);
		send_item(OP_POP_BACK, 0, 0);
		send_item(OP_CONTAINS, 5, 0);
		send_item(OP_REMOVE, 5, 0);
		send_item(3'd6, -1, 0);
		send_item(3'd7, 32'sh7fffffff, 0);
		send_item(OP_PUSH_BACK, 32'sh7fffffff, 0);
		send_item(OP_PUSH_FRONT, 32'sh80000000, 0);
		send_item(OP_CONTAINS, 32'sh7fffffff, 0);
		send_item(OP_REMOVE, 1, 0);
		send_item(OP_REMOVE, 32'sh80000000, 0);
		send_item(OP_POP_BACK, 0, 0);
		for (int i = 0; i < 17; i++)
			send_item(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, i - 1, 0);
		hold_off = 1;
		for (int i = 0; i < 300; i++) begin
			mode = $urandom_range(0, 99);
			if (mode < 22) op = OP_PUSH_FRONT;
			else if (mode < 44) op = OP_PUSH_BACK;
			else if (mode < 54) op = OP_POP_FRONT;
			else if (mode < 64) op = OP_POP_BACK;
			else if (mode < 80) op = OP_CONTAINS;
			else if (mode < 97) op = OP_REMOVE;
			else op = 3'($urandom_range(6, 7));
			send_item(op, pick_value(), i < 40);
		end
		for (int i = 0; i < 1700; i++) begin
			mode = $urandom_range(0, 99);
			if (mode < 18) op = OP_PUSH_FRONT;
			else if (mode < 36) op = OP_PUSH_BACK;
			else if (mode < 48) op = OP_POP_FRONT;
			else if (mode < 60) op = OP_POP_BACK;
			else if (mode < 78) op = OP_CONTAINS;
			else if (mode < 97) op = OP_REMOVE;
			else op = 3'($urandom_range(6, 7));
			send_item(op, pick_value(), (i / 100) % 3 == 0);
		end
		in_valid <= 0;
		sending_done = 1;
	end

	// Finish once every expected result has come, with a short tail for strays.
	initial begin
		wait (sending_done);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("deque_bag_store_tb: PASS");
		else
			$display("deque_bag_store_tb: FAIL");
		$finish;
	end
endmodule
